// ===== hdl/cosine_similarity_stream_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cosine similarity stream block
// Each macro expects signals named clk and arst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_STREAM_DEFINES_SVH
`define COSINE_SIMILARITY_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CSS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/css_pkg.sv =====
// ----------------------------------------------------------------------------
// css_pkg
// Shared constants and types of the cosine similarity stream block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package css_pkg;

	// Default longest vector, in element pairs
	localparam int MAX_DIM_DEF = 4096;

	// Job queue between the accumulating front and the solving back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Result magnitude bits searched by the root unit
	localparam int ROOT_BITS = 16;
	localparam logic [ROOT_BITS-1:0] SIM_MAX = 16'h7FFF;
	localparam logic [ROOT_BITS-1:0] SIM_ONE = 16'h8000;

	// Back end sequencer
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_MUL,
		BK_RINIT,
		BK_ROOT_A,
		BK_ROOT_B,
		BK_FIN,
		BK_DONE
	} bk_state_t;

endpackage

// ===== hdl/css_front.sv =====
// ----------------------------------------------------------------------------
// css_front
// Input stage: registers element pairs, multiplies, and accumulates the dot
// product and both squared norms; hands a finished vector to the job queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module css_front
	import css_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic signed [15:0]         element_a,
	input  logic signed [15:0]         element_b,
	input  logic                       last,
	output logic                       full,
	input  logic [QCNT_W-1:0]          q_cnt,
	output logic                       job_push,
	output logic [3*$clog2(MAX_DIM)+94:0] job_data
);

	localparam int NW = 31 + $clog2(MAX_DIM);
	localparam int DW = NW + 1;
	localparam int CW = $clog2(MAX_DIM + 1);

	// stage 1: captured request
	logic signed [15:0] a_s1, b_s1;
	logic               last_s1, vld_s1;
	// stage 2: products
	logic signed [31:0] pab_s2;
	logic [30:0]        paa_s2, pbb_s2;
	logic               last_s2, vld_s2;
	// accumulators
	logic signed [DW-1:0] dot_q;
	logic [NW-1:0]        na_q, nb_q;
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;

	logic                 accept;
	logic [QCNT_W:0]      rsv;
	logic signed [31:0]   paa_c, pbb_c;
	logic                 room;
	logic signed [DW-1:0] dot_n;
	logic [NW-1:0]        na_n, nb_n;
	logic [CW-1:0]        cnt_n;
	logic                 ovf_n;

	// Queue slots already spoken for by vectors still in the pipe
	always_comb begin
		rsv = {1'b0, q_cnt}
			+ {{QCNT_W{1'b0}}, vld_s1 & last_s1}
			+ {{QCNT_W{1'b0}}, vld_s2 & last_s2};
		full = (rsv >= (QCNT_W+1)'(QDEPTH));
	end

	assign accept = push & ~full;

	// Squares are never negative and fit 31 bits
	assign paa_c = a_s1 * a_s1;
	assign pbb_c = b_s1 * b_s1;

	// Accumulate unless the vector already holds MAX_DIM pairs
	always_comb begin
		room  = (cnt_q < CW'(MAX_DIM));
		dot_n = room ? dot_q + DW'(pab_s2) : dot_q;
		na_n  = room ? na_q + NW'(paa_s2) : na_q;
		nb_n  = room ? nb_q + NW'(pbb_s2) : nb_q;
		cnt_n = room ? cnt_q + CW'(1) : cnt_q;
		ovf_n = ovf_q | ~room;
	end

	assign job_push = vld_s2 & last_s2;
	assign job_data = {ovf_n, dot_n, na_n, nb_n};

	// Pipeline control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dot_q  <= '0;
			na_q   <= '0;
			nb_q   <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			if (vld_s2) begin
				if (last_s2) begin
					dot_q <= '0;
					na_q  <= '0;
					nb_q  <= '0;
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					dot_q <= dot_n;
					na_q  <= na_n;
					nb_q  <= nb_n;
					cnt_q <= cnt_n;
					ovf_q <= ovf_n;
				end
			end
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1    <= element_a;
			b_s1    <= element_b;
			last_s1 <= last;
		end
		pab_s2  <= a_s1 * b_s1;
		paa_s2  <= paa_c[30:0];
		pbb_s2  <= pbb_c[30:0];
		last_s2 <= last_s1;
	end

endmodule

// ===== hdl/css_job_queue.sv =====
// ----------------------------------------------------------------------------
// css_job_queue
// Small FIFO of finished accumulator sets; read data is registered on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cosine_similarity_stream_defines.svh"

module css_job_queue
	import css_pkg::*;
#(
	parameter int W = 87
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [W-1:0]      wr_data,
	input  logic              pop,
	output logic [W-1:0]      rd_data,
	output logic              empty,
	output logic [QCNT_W-1:0] cnt
);

	logic [W-1:0]      mem [QDEPTH];
	logic [W-1:0]      rd_data_q;
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty   = (cnt_q == '0);
	assign cnt     = cnt_q;
	assign rd_data = rd_data_q;

	// Storage and registered read port
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`CSS_ASSERT_IMPL(a_no_push_full, push, cnt_q < QCNT_W'(QDEPTH), "job pushed into full queue")
	`CSS_ASSERT_IMPL(a_no_pop_empty, pop, cnt_q != '0, "job popped from empty queue")

endmodule

// ===== hdl/css_back.sv =====
// ----------------------------------------------------------------------------
// css_back
// Solver: squares the dot product and multiplies the norms with shift-add
// units, then finds the Q1.15 similarity one bit at a time, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cosine_similarity_stream_defines.svh"

module css_back
	import css_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  logic [3*$clog2(MAX_DIM)+94:0] q_data,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [15:0]         similarity,
	output logic                       too_long
);

	localparam int NW  = 31 + $clog2(MAX_DIM);
	localparam int DW  = NW + 1;
	localparam int PW  = 2 * NW;
	localparam int EW  = PW + 32;
	localparam int MCW = $clog2(NW + 1);
	localparam int JW  = 1 + DW + 2 * NW;

	bk_state_t state_q, state_n;

	// job fields
	logic                 ovf_j;
	logic [DW-1:0]        dot_j, dabs_j;
	logic [NW-1:0]        na_j, nb_j;

	// multiply phase
	logic [NW-1:0]        mcd_q, mpd_q, mca_q, mpb_q;
	logic [PW-1:0]        accd_q, accp_q;
	logic [MCW-1:0]       mcnt_q;
	logic                 neg_q;

	// root phase
	logic [EW-1:0]        e_q, fs_q, ps2_q, t_q, fsp_q;
	logic [EW-1:0]        rfull, cand;
	logic                 ok;
	logic [3:0]           k_q;
	logic [ROOT_BITS-1:0] r_q;

	// result
	logic [15:0]          sim_q;
	logic                 long_q;
	logic                 res_valid_q;
	logic [15:0]          res_sim_q;
	logic                 res_long_q;

	assign ovf_j  = q_data[JW-1];
	assign dot_j  = q_data[JW-2 -: DW];
	assign na_j   = q_data[2*NW-1:NW];
	assign nb_j   = q_data[NW-1:0];
	assign dabs_j = dot_j[DW-1] ? (~dot_j + DW'(1)) : dot_j;

	// Candidate r^2*P against dot^2 * 2^30
	assign rfull = EW'({accd_q, 30'd0});
	assign cand  = t_q + ps2_q;
	assign ok    = (cand <= rfull);

	assign empty      = ~res_valid_q;
	assign similarity = res_sim_q;
	assign too_long   = res_long_q;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and queue read
	always_comb begin
		state_n = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_n = BK_LOAD;
				end
			end
			BK_LOAD: begin
				if (ovf_j || na_j == '0 || nb_j == '0) begin
					state_n = BK_DONE;
				end else begin
					state_n = BK_MUL;
				end
			end
			BK_MUL: begin
				if (mcnt_q == MCW'(1)) begin
					state_n = BK_RINIT;
				end
			end
			BK_RINIT:  state_n = BK_ROOT_A;
			BK_ROOT_A: state_n = BK_ROOT_B;
			BK_ROOT_B: begin
				state_n = (k_q == 4'd0) ? BK_FIN : BK_ROOT_A;
			end
			BK_FIN:    state_n = BK_DONE;
			BK_DONE: begin
				if (!res_valid_q) begin
					state_n = BK_IDLE;
				end
			end
		endcase
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BK_LOAD: begin
				mcd_q  <= dabs_j[NW-1:0];
				mpd_q  <= dabs_j[NW-1:0];
				mca_q  <= na_j;
				mpb_q  <= nb_j;
				accd_q <= '0;
				accp_q <= '0;
				mcnt_q <= MCW'(NW);
				neg_q  <= dot_j[DW-1];
				sim_q  <= '0;
				long_q <= ovf_j;
			end
			BK_MUL: begin
				// MSB-first shift-add: dot^2 and normA*normB together
				accd_q <= {accd_q[PW-2:0], 1'b0} + (mpd_q[NW-1] ? PW'(mcd_q) : '0);
				accp_q <= {accp_q[PW-2:0], 1'b0} + (mpb_q[NW-1] ? PW'(mca_q) : '0);
				mpd_q  <= {mpd_q[NW-2:0], 1'b0};
				mpb_q  <= {mpb_q[NW-2:0], 1'b0};
				mcnt_q <= mcnt_q - MCW'(1);
			end
			BK_RINIT: begin
				e_q   <= '0;
				fs_q  <= '0;
				ps2_q <= EW'({accp_q, 30'd0});
				k_q   <= 4'd15;
				r_q   <= '0;
			end
			BK_ROOT_A: begin
				// fs holds r*P << (k+1), ps2 holds P << 2k
				t_q   <= e_q + fs_q;
				fsp_q <= fs_q + {ps2_q[EW-2:0], 1'b0};
			end
			BK_ROOT_B: begin
				if (ok) begin
					e_q <= cand;
				end
				fs_q     <= (ok ? fsp_q : fs_q) >> 1;
				ps2_q    <= ps2_q >> 2;
				r_q[k_q] <= ok;
				k_q      <= k_q - 4'd1;
			end
			BK_FIN: begin
				// exact +1 saturates, exact -1 is representable
				if (neg_q) begin
					sim_q <= (~r_q) + 16'd1;
				end else begin
					sim_q <= r_q[ROOT_BITS-1] ? SIM_MAX : r_q;
				end
			end
			default: begin
			end
		endcase
		if (state_q == BK_DONE && !res_valid_q) begin
			res_sim_q  <= sim_q;
			res_long_q <= long_q;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == BK_DONE && !res_valid_q) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	`CSS_ASSERT_IMPL(a_e_bounded, state_q == BK_ROOT_A, e_q <= rfull, "root partial exceeds bound")
	`CSS_ASSERT_IMPL(a_r_bounded, state_q == BK_FIN, r_q <= SIM_ONE, "root above one")
	`CSS_ASSERT_NEXT(a_pop_load, q_pop, state_q == BK_LOAD, "queue read without load")

endmodule

// ===== hdl/cosine_similarity_stream.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_stream
// Streaming cosine similarity of two signed 16-bit vectors, Q1.15 result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive element_a, element_b and last with push; a request is
//   taken on a clock edge with push high and full low. One pair per cycle is
//   sustained while the job queue has room. The pair marked last closes the
//   vector; pairs beyond MAX_DIM are dropped and flag the result too_long.
//   Result channel: while empty is low, similarity and too_long show the
//   oldest result; pop high on a clock edge takes it. Only vectors give
//   results, one each.
//   Path to a result: after the edge that takes the last pair, the job
//   passes the two front stages, the queue write and read, a shift-add
//   multiply over the NW multiplier bits, NW being 31 + clog2(MAX_DIM), and
//   a root search that settles one result bit per pass through BK_ROOT_A
//   and BK_ROOT_B, and then empty falls. Zero-norm and too-long vectors
//   skip the multiply and root search. The back end solves one vector at a
//   time, so short vectors can fill the four-entry job queue and raise full.
//   A stalled receiver holds the result register; the back end then waits,
//   the queue fills, and full rises; nothing is lost.
//   Reset (arst_n low) clears accumulators, queue and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cosine_similarity_stream
	import css_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] element_a,
	input  logic signed [15:0] element_b,
	input  logic               last,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] similarity,
	output logic               too_long
);

	localparam int JW = 3 * $clog2(MAX_DIM) + 95;

	logic              job_push;
	logic [JW-1:0]     job_wdata;
	logic [JW-1:0]     job_rdata;
	logic              job_pop;
	logic              job_empty;
	logic [QCNT_W-1:0] job_cnt;

	css_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.element_a (element_a),
		.element_b (element_b),
		.last      (last),
		.full      (full),
		.q_cnt     (job_cnt),
		.job_push  (job_push),
		.job_data  (job_wdata)
	);

	css_job_queue #(
		.W (JW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_wdata),
		.pop     (job_pop),
		.rd_data (job_rdata),
		.empty   (job_empty),
		.cnt     (job_cnt)
	);

	css_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (job_empty),
		.q_pop      (job_pop),
		.q_data     (job_rdata),
		.empty      (empty),
		.pop        (pop),
		.similarity (similarity),
		.too_long   (too_long)
	);

endmodule
